[design/escaped_receiver_frame_serializer_macros.svh]
// Assertion helpers for the frame serializer.
`ifndef ESCAPED_RECEIVER_FRAME_SERIALIZER_MACROS_SVH
`define ESCAPED_RECEIVER_FRAME_SERIALIZER_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ERFS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// cond must never be seen at a clock edge out of reset
`define ERFS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ERFS_ASSERT(label, clk, rst_n, prop, msg)
`define ERFS_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[design/erfs_pkg.sv]
package erfs_pkg;

	localparam int LEN_W = 9;
	localparam int TS_W  = 48;
	localparam int ID_W  = 64;

	// escape byte of the feed
	localparam logic [7:0] ESC_BYTE = 8'h1A;

	// Mode S payload sizes, given in bytes
	localparam logic [LEN_W-1:0] MODES_SHORT_LEN = LEN_W'(56 / 8);
	localparam logic [LEN_W-1:0] MODES_LONG_LEN  = LEN_W'(112 / 8);

	// command queue between front and back
	localparam int CMD_DEPTH = 2;

	// request action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	typedef enum logic [1:0] {
		KIND_MODES        = 2'd0,
		KIND_MODES_INGEST = 2'd1,
		KIND_UAT_ADSB     = 2'd2,
		KIND_UAT_UPLINK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_SHORT_CODE  = 3'd0,
		REG_LONG_CODE   = 3'd1,
		REG_UAT_CODE    = 3'd2,
		REG_INGEST_CODE = 3'd3,
		REG_UAT_SHORT   = 3'd4,
		REG_UAT_LONG    = 3'd5,
		REG_UAT_UPLINK  = 3'd6,
		REG_RECV_IDENT  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]      short_code;
		logic [7:0]      long_code;
		logic [7:0]      uat_code;
		logic [7:0]      ingest_code;
		logic [7:0]      uat_short_char;
		logic [7:0]      uat_long_char;
		logic [7:0]      uat_uplink_char;
		logic [ID_W-1:0] recv_ident;
	} cfg_t;

	// one unit of work for the back end: a frame header or one payload byte
	typedef struct packed {
		logic            is_hdr;
		logic            ingest;
		logic            has_sub;
		logic [7:0]      type_code;
		logic [7:0]      sub_char;
		logic [TS_W-1:0] ts;
		logic [7:0]      power;
		logic [7:0]      data;
		logic            frame_end;
	} cmd_t;

	// byte sequencer steps of the back end
	typedef enum logic [4:0] {
		S_ESC0, S_INGEST,
		S_ID0, S_ID1, S_ID2, S_ID3, S_ID4, S_ID5, S_ID6, S_ID7,
		S_ESC1, S_TYPE, S_SUB,
		S_TS0, S_TS1, S_TS2, S_TS3, S_TS4, S_TS5,
		S_POWER, S_DATA
	} step_t;

endpackage

[design/erfs_front.sv]
`include "escaped_receiver_frame_serializer_macros.svh"

module erfs_front import erfs_pkg::*; #(
	parameter int UAT_SHORT_LEN  = 18,
	parameter int UAT_LONG_LEN   = 34,
	parameter int UAT_UPLINK_LEN = 432
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [1:0]       frame_kind,
	input  logic [LEN_W-1:0] payload_len,
	input  logic [TS_W-1:0]  timestamp,
	input  logic [7:0]       power_level,
	input  logic [7:0]       data_byte,
	input  cfg_t             cfg,
	input  logic             fifo_full,
	output logic             push,
	output cmd_t             push_cmd
);

	localparam logic [LEN_W-1:0] UAT_SHORT_L  = LEN_W'(UAT_SHORT_LEN);
	localparam logic [LEN_W-1:0] UAT_LONG_L   = LEN_W'(UAT_LONG_LEN);
	localparam logic [LEN_W-1:0] UAT_UPLINK_L = LEN_W'(UAT_UPLINK_LEN);

	logic [LEN_W-1:0] rem_q;
	logic             disc_q;
	logic [LEN_W-1:0] rem_dec;
	logic             accept;
	logic             hdr_ok;
	logic             has_sub;
	logic [7:0]       type_code;
	logic [7:0]       sub_char;
	logic             data_live;

	assign in_ready  = !fifo_full;
	assign accept    = in_valid && in_ready;
	assign rem_dec   = rem_q - LEN_W'(1);
	assign data_live = (rem_q != '0) && !disc_q;

	// length check and header codes of a start request
	always_comb begin
		hdr_ok    = 1'b0;
		has_sub   = 1'b0;
		type_code = cfg.short_code;
		sub_char  = cfg.uat_short_char;
		case (kind_t'(frame_kind))
			KIND_MODES, KIND_MODES_INGEST: begin
				if (payload_len == MODES_SHORT_LEN) begin
					hdr_ok = 1'b1;
				end else if (payload_len == MODES_LONG_LEN) begin
					hdr_ok    = 1'b1;
					type_code = cfg.long_code;
				end
			end
			KIND_UAT_ADSB: begin
				type_code = cfg.uat_code;
				has_sub   = 1'b1;
				if (payload_len == UAT_SHORT_L) begin
					hdr_ok = 1'b1;
				end else if (payload_len == UAT_LONG_L) begin
					hdr_ok   = 1'b1;
					sub_char = cfg.uat_long_char;
				end
			end
			KIND_UAT_UPLINK: begin
				type_code = cfg.uat_code;
				has_sub   = 1'b1;
				sub_char  = cfg.uat_uplink_char;
				hdr_ok    = (payload_len == UAT_UPLINK_L);
			end
			default: begin
				hdr_ok = 1'b0;
			end
		endcase
	end

	// command handed to the queue
	always_comb begin
		push_cmd.is_hdr    = (action == ACT_START);
		push_cmd.ingest    = (kind_t'(frame_kind) == KIND_MODES_INGEST);
		push_cmd.has_sub   = has_sub;
		push_cmd.type_code = type_code;
		push_cmd.sub_char  = sub_char;
		push_cmd.ts        = timestamp;
		push_cmd.power     = power_level;
		push_cmd.data      = data_byte;
		push_cmd.frame_end = (action == ACT_START) ? (payload_len == '0) : (rem_dec == '0);
		push = accept && ((action == ACT_START) ? hdr_ok : data_live);
	end

	// payload byte count and discard flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			disc_q <= 1'b0;
		end else if (accept) begin
			if (action == ACT_START) begin
				rem_q  <= payload_len;
				disc_q <= !hdr_ok && (payload_len != '0);
			end else if (rem_q != '0) begin
				rem_q <= rem_dec;
				if (rem_dec == '0) begin
					disc_q <= 1'b0;
				end
			end
		end
	end

	`ERFS_ASSERT(a_disc_has_count, clk, arst_n, disc_q |-> (rem_q != '0), "discard with no bytes left")

endmodule

[design/erfs_cmd_fifo.sv]
`include "escaped_receiver_frame_serializer_macros.svh"

module erfs_cmd_fifo import erfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(CMD_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ERFS_NEVER(a_no_overflow, clk, arst_n, push && full, "command queue overflow")
	`ERFS_NEVER(a_no_underflow, clk, arst_n, pop && !head_valid, "command queue underflow")

endmodule

[design/erfs_back.sv]
`include "escaped_receiver_frame_serializer_macros.svh"

module erfs_back import erfs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  cmd_t            head_cmd,
	output logic            pop,
	input  logic [7:0]      ingest_code,
	input  logic [ID_W-1:0] recv_ident,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            frame_end
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       end_q;
	logic       dup_q;
	logic       active_q;
	step_t      step_q;

	step_t      first_step;
	step_t      cur_step;
	step_t      next_step;
	logic [7:0] cur_byte;
	logic       esc_ok;
	logic       last_step;
	logic       dup_now;
	logic       advance;
	logic [2:0] id_idx;
	logic [2:0] ts_sel;

	assign advance = !out_valid_q || out_ready;

	// where a fresh command starts
	always_comb begin
		if (!head_cmd.is_hdr) begin
			first_step = S_DATA;
		end else if (head_cmd.ingest) begin
			first_step = S_ESC0;
		end else begin
			first_step = S_ESC1;
		end
		cur_step = active_q ? step_q : first_step;
	end

	// next step
	always_comb begin
		case (cur_step)
			S_TYPE:  next_step = head_cmd.has_sub ? S_SUB : S_TS0;
			S_POWER: next_step = S_POWER;
			S_DATA:  next_step = S_DATA;
			default: next_step = step_t'(cur_step + 5'd1);
		endcase
		last_step = (cur_step == S_POWER) || (cur_step == S_DATA);
	end

	// byte of the current step
	always_comb begin
		id_idx   = 3'(cur_step - S_ID0);
		ts_sel   = 3'd5 - 3'(cur_step - S_TS0);
		cur_byte = ESC_BYTE;
		esc_ok   = 1'b1;
		case (cur_step)
			S_ESC0, S_ESC1: begin
				esc_ok = 1'b0;
			end
			S_INGEST: begin
				cur_byte = ingest_code;
				esc_ok   = 1'b0;
			end
			S_ID0, S_ID1, S_ID2, S_ID3, S_ID4, S_ID5, S_ID6, S_ID7: begin
				cur_byte = recv_ident[{~id_idx, 3'b000} +: 8];
			end
			S_TYPE: begin
				cur_byte = head_cmd.type_code;
				esc_ok   = 1'b0;
			end
			S_SUB: begin
				cur_byte = head_cmd.sub_char;
			end
			S_TS0, S_TS1, S_TS2, S_TS3, S_TS4, S_TS5: begin
				cur_byte = head_cmd.ts[{ts_sel, 3'b000} +: 8];
			end
			S_POWER: begin
				cur_byte = head_cmd.power;
			end
			S_DATA: begin
				cur_byte = head_cmd.data;
			end
			default: begin
				esc_ok = 1'b0;
			end
		endcase
		// first copy of an escape byte; the step repeats once
		dup_now = esc_ok && (cur_byte == ESC_BYTE) && !dup_q;
		pop     = advance && head_valid && !dup_now && last_step;
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dup_q       <= 1'b0;
			active_q    <= 1'b0;
			step_q      <= S_ESC0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (dup_now) begin
					dup_q    <= 1'b1;
					active_q <= 1'b1;
					step_q   <= cur_step;
				end else begin
					dup_q <= 1'b0;
					if (last_step) begin
						active_q <= 1'b0;
					end else begin
						active_q <= 1'b1;
						step_q   <= next_step;
					end
				end
			end
		end
	end

	// output byte register
	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_byte_q <= cur_byte;
			last_q     <= !dup_now && last_step;
			end_q      <= !dup_now && last_step && head_cmd.frame_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign frame_end   = end_q;

	`ERFS_ASSERT(a_dup_after_esc, clk, arst_n, dup_q |-> (out_valid_q && out_byte_q == ESC_BYTE), "escape repeat without escape byte")
	`ERFS_ASSERT(a_active_has_cmd, clk, arst_n, active_q |-> head_valid, "sequencer busy with empty queue")
	`ERFS_ASSERT(a_end_is_last, clk, arst_n, (out_valid_q && end_q) |-> last_q, "frame end not on last byte of run")

endmodule

[design/escaped_receiver_frame_serializer.sv]
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_ready   action, frame_kind, payload_len, timestamp,
//                                            power_level, data_byte
// out       result     out_valid / out_ready out_byte, last_of_run, frame_end
// cfg       write      cfg_wr_en             cfg_index, cfg_data
//
// Output runs at one byte per cycle while the queue is not empty and out_ready is high;
// a payload byte gives 1 or 2 bytes, a header 9 to 34, set by the back end byte sequencer.
// On an empty queue the first byte of a request passes through the command queue and
// then the output byte register before it shows on out_valid.
// in_ready drops only while the two-entry command queue is full.
// Requests that produce no bytes are absorbed by the front end and never reach the queue.
// Reset clears the queue and loads the register defaults; no clearing pass.
module escaped_receiver_frame_serializer import erfs_pkg::*; #(
	parameter int UAT_SHORT_LEN  = 18,
	parameter int UAT_LONG_LEN   = 34,
	parameter int UAT_UPLINK_LEN = 432
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [1:0]       frame_kind,
	input  logic [LEN_W-1:0] payload_len,
	input  logic [TS_W-1:0]  timestamp,
	input  logic [7:0]       power_level,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             frame_end,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  logic [ID_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic fifo_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_code      <= 8'd50;
			cfg_q.long_code       <= 8'd51;
			cfg_q.uat_code        <= 8'd235;
			cfg_q.ingest_code     <= 8'd232;
			cfg_q.uat_short_char  <= 8'd83;
			cfg_q.uat_long_char   <= 8'd76;
			cfg_q.uat_uplink_char <= 8'd85;
			cfg_q.recv_ident      <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_SHORT_CODE:  cfg_q.short_code      <= cfg_data[7:0];
				REG_LONG_CODE:   cfg_q.long_code       <= cfg_data[7:0];
				REG_UAT_CODE:    cfg_q.uat_code        <= cfg_data[7:0];
				REG_INGEST_CODE: cfg_q.ingest_code     <= cfg_data[7:0];
				REG_UAT_SHORT:   cfg_q.uat_short_char  <= cfg_data[7:0];
				REG_UAT_LONG:    cfg_q.uat_long_char   <= cfg_data[7:0];
				REG_UAT_UPLINK:  cfg_q.uat_uplink_char <= cfg_data[7:0];
				REG_RECV_IDENT:  cfg_q.recv_ident      <= cfg_data;
				default:         cfg_q                 <= cfg_q;
			endcase
		end
	end

	erfs_front #(
		.UAT_SHORT_LEN (UAT_SHORT_LEN),
		.UAT_LONG_LEN  (UAT_LONG_LEN),
		.UAT_UPLINK_LEN(UAT_UPLINK_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.frame_kind (frame_kind),
		.payload_len(payload_len),
		.timestamp  (timestamp),
		.power_level(power_level),
		.data_byte  (data_byte),
		.cfg        (cfg_q),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	erfs_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	erfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.ingest_code(cfg_q.ingest_code),
		.recv_ident (cfg_q.recv_ident),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.frame_end  (frame_end)
	);

endmodule

[test/tb_escaped_receiver_frame_serializer.sv]
module tb_escaped_receiver_frame_serializer;
	import erfs_pkg::*;

	localparam int UAT_SHORT_LEN  = 18;
	localparam int UAT_LONG_LEN   = 34;
	localparam int UAT_UPLINK_LEN = 432;

	// cycles to let the front end settle after the last byte has come out
	localparam int SETTLE_CYCLES = 10;
	// marks a table row whose bytes come from the predictor
	localparam int PREDICTED = -1;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       fend;
	} feed_byte_t;

	typedef struct {
		logic             action;
		kind_t            kind;
		logic [LEN_W-1:0] len;
		logic [TS_W-1:0]  ts;
		logic [7:0]       power;
		logic [7:0]       data;
	} req_t;

	typedef struct {
		req_t rq;
		int   n_typ;
		logic typ_end;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             action = ACT_START;
	logic [1:0]       frame_kind = KIND_MODES;
	logic [LEN_W-1:0] payload_len = '0;
	logic [TS_W-1:0]  timestamp = '0;
	logic [7:0]       power_level = '0;
	logic [7:0]       data_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       out_byte;
	logic             last_of_run;
	logic             frame_end;
	logic             cfg_wr_en = 1'b0;
	logic [2:0]       cfg_index = REG_SHORT_CODE;
	logic [ID_W-1:0]  cfg_data = '0;

	escaped_receiver_frame_serializer #(
		.UAT_SHORT_LEN (UAT_SHORT_LEN),
		.UAT_LONG_LEN  (UAT_LONG_LEN),
		.UAT_UPLINK_LEN(UAT_UPLINK_LEN)
	) DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register copy
	cfg_t            regs;
	logic [LEN_W-1:0] bytes_left;
	logic            dropping;
	feed_byte_t      beats[$];
	feed_byte_t      pending_bytes[$];
	dir_row_t        dir_rows[$];
	feed_byte_t      want;

	int tx_gap_pct;
	int rx_stall_pct;
	int sent;
	int errors;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic logic accepted_len(kind_t k, logic [LEN_W-1:0] len);
		case (k)
			KIND_MODES, KIND_MODES_INGEST: return len == MODES_SHORT_LEN || len == MODES_LONG_LEN;
			KIND_UAT_ADSB: return len == UAT_SHORT_LEN || len == UAT_LONG_LEN;
			default: return len == UAT_UPLINK_LEN;
		endcase
	endfunction

	function automatic void emit_raw(logic [7:0] b);
		beats.push_back('{b, 1'b0, 1'b0});
	endfunction

	function automatic void emit_escaped(logic [7:0] b);
		emit_raw(b);
		if (b == ESC_BYTE)
			emit_raw(b);
	endfunction

	// fills beats with the feed bytes one request causes
	function automatic void encode_request(req_t rq);
		logic ok;
		logic sub_on;
		logic fend;
		logic [7:0] code;
		logic [7:0] sub;
		int i;
		fend = 1'b0;
		beats.delete();
		if (rq.action == ACT_START) begin
			ok = accepted_len(rq.kind, rq.len);
			sub_on = (rq.kind == KIND_UAT_ADSB) || (rq.kind == KIND_UAT_UPLINK);
			if (sub_on)
				code = regs.uat_code;
			else
				code = (rq.len == MODES_SHORT_LEN) ? regs.short_code : regs.long_code;
			if (rq.kind == KIND_UAT_UPLINK)
				sub = regs.uat_uplink_char;
			else
				sub = (rq.len == UAT_SHORT_LEN) ? regs.uat_short_char : regs.uat_long_char;
			bytes_left = rq.len;
			// a rejected start drops its payload, no ingest prefix
			dropping = !ok && (rq.len != 0);
			if (ok) begin
				if (rq.kind == KIND_MODES_INGEST) begin
					emit_raw(ESC_BYTE);
					emit_raw(regs.ingest_code);
					for (i = 7; i >= 0; i--)
						emit_escaped(regs.recv_ident[i*8 +: 8]);
				end
				emit_raw(ESC_BYTE);
				emit_raw(code);
				if (sub_on)
					emit_escaped(sub);
				for (i = 5; i >= 0; i--)
					emit_escaped(rq.ts[i*8 +: 8]);
				emit_escaped(rq.power);
				fend = (bytes_left == 0);
			end
		end else if (bytes_left != 0) begin
			bytes_left = bytes_left - 1'b1;
			if (dropping) begin
				if (bytes_left == 0)
					dropping = 1'b0;
			end else begin
				emit_escaped(rq.data);
				fend = (bytes_left == 0);
			end
		end
		if (beats.size() != 0) begin
			beats[beats.size()-1].last = 1'b1;
			beats[beats.size()-1].fend = fend;
		end
	endfunction

	// ---------------------------------------------------------------
	// request generation
	// ---------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		return ($urandom_range(4) == 0) ? ESC_BYTE : 8'($urandom_range(255));
	endfunction

	function automatic req_t start_req(kind_t kd, int len);
		req_t rq;
		int i;
		rq.action = ACT_START;
		rq.kind = kd;
		rq.len = LEN_W'(len);
		for (i = 0; i < 6; i++)
			rq.ts[i*8 +: 8] = rand_byte();
		rq.power = rand_byte();
		rq.data = 8'($urandom_range(255));
		return rq;
	endfunction

	// header fields are don't-care on data requests, so keep them moving
	function automatic req_t data_req(logic [7:0] d);
		req_t rq;
		rq = start_req(kind_t'($urandom_range(3)), $urandom_range(511));
		rq.action = ACT_DATA;
		rq.data = d;
		return rq;
	endfunction

	task automatic add_row(logic act, kind_t kd, int len, logic [TS_W-1:0] ts,
			logic [7:0] pw, logic [7:0] d, int n_typ, logic typ_end);
		dir_row_t r;
		r.rq = '{act, kd, LEN_W'(len), ts, pw, d};
		r.n_typ = n_typ;
		r.typ_end = typ_end;
		dir_rows.push_back(r);
	endtask

	// drive one request and book its bytes once accepted
	task automatic send_req(req_t rq, int n_typ, logic typ_end);
		int k;
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= rq.action;
		frame_kind <= rq.kind;
		payload_len <= rq.len;
		timestamp <= rq.ts;
		power_level <= rq.power;
		data_byte <= rq.data;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		encode_request(rq);
		// typed rows: the table gives the count, the byte is the data byte
		if (n_typ != PREDICTED) begin
			beats.delete();
			for (k = 0; k < n_typ; k++)
				beats.push_back('{rq.data, k == n_typ - 1, (k == n_typ - 1) && typ_end});
		end
		foreach (beats[j])
			pending_bytes.push_back(beats[j]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [ID_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SHORT_CODE:  regs.short_code = val[7:0];
			REG_LONG_CODE:   regs.long_code = val[7:0];
			REG_UAT_CODE:    regs.uat_code = val[7:0];
			REG_INGEST_CODE: regs.ingest_code = val[7:0];
			REG_UAT_SHORT:   regs.uat_short_char = val[7:0];
			REG_UAT_LONG:    regs.uat_long_char = val[7:0];
			REG_UAT_UPLINK:  regs.uat_uplink_char = val[7:0];
			default:         regs.recv_ident = val;
		endcase
	endtask

	task automatic load_settings(logic [7:0] sc, logic [7:0] lc, logic [7:0] uc,
			logic [7:0] ic, logic [7:0] usc, logic [7:0] ulc, logic [7:0] upc,
			logic [ID_W-1:0] id);
		write_reg(REG_SHORT_CODE, ID_W'(sc));
		write_reg(REG_LONG_CODE, ID_W'(lc));
		write_reg(REG_UAT_CODE, ID_W'(uc));
		write_reg(REG_INGEST_CODE, ID_W'(ic));
		write_reg(REG_UAT_SHORT, ID_W'(usc));
		write_reg(REG_UAT_LONG, ID_W'(ulc));
		write_reg(REG_UAT_UPLINK, ID_W'(upc));
		write_reg(REG_RECV_IDENT, id);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly whole frames with random content, some cut short,
	// some rejected starts, and a little noise; target counts requests
	task automatic run_random(int target);
		int goal;
		int pick;
		int n;
		int k;
		int len;
		kind_t kd;
		logic paused;
		goal = sent + target;
		paused = 1'b0;
		while (sent < goal) begin
			if (!paused && sent >= goal - target / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			kd = kind_t'($urandom_range(3));
			if (pick < 78) begin
				case (kd)
					KIND_MODES, KIND_MODES_INGEST:
						len = $urandom_range(1) ? MODES_LONG_LEN : MODES_SHORT_LEN;
					KIND_UAT_ADSB:
						len = $urandom_range(1) ? UAT_LONG_LEN : UAT_SHORT_LEN;
					default:
						len = UAT_UPLINK_LEN;
				endcase
				n = len;
				// uplink frames are always cut short, the rest now and then
				if (pick >= 65 || kd == KIND_UAT_UPLINK)
					n = $urandom_range(0, (len > 21) ? 20 : len - 1);
				if (n > goal - sent - 1)
					n = goal - sent - 1;
				send_req(start_req(kd, len), PREDICTED, 1'b0);
				for (k = 0; k < n; k++)
					send_req(data_req(rand_byte()), PREDICTED, 1'b0);
			end else if (pick < 90) begin
				do
					len = ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(40);
				while (accepted_len(kd, LEN_W'(len)));
				n = (len <= 40) ? len + $urandom_range(2) : $urandom_range(10);
				if (n > goal - sent - 1)
					n = goal - sent - 1;
				send_req(start_req(kd, len), PREDICTED, 1'b0);
				for (k = 0; k < n; k++)
					send_req(data_req(rand_byte()), PREDICTED, 1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					req_t rq;
					rq.action = 1'($urandom_range(1));
					rq.kind = kind_t'($urandom_range(3));
					rq.len = LEN_W'($urandom_range(511));
					rq.ts = {16'($urandom), $urandom};
					rq.power = 8'($urandom_range(255));
					rq.data = 8'($urandom_range(255));
					send_req(rq, PREDICTED, 1'b0);
				end
			end
		end
	endtask

	task automatic note_error(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// ---------------------------------------------------------------
	// output side: random stalls, compare each byte with the oldest one due
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_bytes.size() == 0) begin
					note_error($sformatf("unexpected byte %02h last %0b end %0b",
						out_byte, last_of_run, frame_end));
				end else begin
					want = pending_bytes.pop_front();
					if (out_byte !== want.value || last_of_run !== want.last ||
							frame_end !== want.fend)
						note_error($sformatf(
							"byte exp %02h/%0b/%0b got %02h/%0b/%0b (byte/last/end)",
							want.value, want.last, want.fend,
							out_byte, last_of_run, frame_end));
				end
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		#(8 * 400000);
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		regs = {8'd50, 8'd51, 8'd235, 8'd232, 8'd83, 8'd76, 8'd85, 64'd0};
		bytes_left = '0;
		dropping = 1'b0;
		sent = 0;
		errors = 0;
		tx_gap_pct = 34;
		rx_stall_pct = 50;

		// directed rows, reset register values
		//       act        kind               len  timestamp        pwr    data   bytes      end
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h5A, 0,         0); // stray
		add_row(ACT_START, KIND_MODES,         7,  48'h0,           8'h00, 8'h00, PREDICTED, 0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h00, 1,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'hFF, 1,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h1A, 2,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h55, 1,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'hAA, 1,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h01, 1,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h1A, 2,         1);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h77, 0,         0); // stray
		add_row(ACT_START, KIND_MODES_INGEST,  14, 48'hFFFFFFFFFFFF, 8'h1A, 8'h00, PREDICTED, 0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h1A, 2,         0);
		// start during a frame aborts it
		add_row(ACT_START, KIND_UAT_ADSB,      18, 48'h1A1A1A1A1A1A, 8'hFF, 8'h00, PREDICTED, 0);
		add_row(ACT_START, KIND_UAT_ADSB,      34, 48'h0123456789AB, 8'h00, 8'h00, PREDICTED, 0);
		add_row(ACT_START, KIND_UAT_UPLINK,    432, 48'h1A00FF1A00FF, 8'h80, 8'h00, PREDICTED, 0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h1A, 2,         0);
		// zero length start: rejected, nothing to drop
		add_row(ACT_START, KIND_MODES,         0,  48'h0,           8'h00, 8'h00, 0,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h10, 0,         0);
		// rejected ingest frame: no prefix, payload dropped
		add_row(ACT_START, KIND_MODES_INGEST,  5,  48'h0,           8'h00, 8'h00, 0,         0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'h1A, 0,         0);
		add_row(ACT_START, KIND_UAT_UPLINK,    511, 48'hFFFFFFFFFFFF, 8'hFF, 8'h00, 0,        0);
		add_row(ACT_DATA,  KIND_MODES,         0,  48'h0,           8'h00, 8'hFF, 0,         0);
		// start aborts a discard
		add_row(ACT_START, KIND_MODES,         14, 48'h0,           8'h1A, 8'h00, PREDICTED, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].rq, dir_rows[i].n_typ, dir_rows[i].typ_end);
		drain_results();

		// escape byte as the UAT type code and short subtype, extremes elsewhere
		load_settings(8'h00, 8'hFF, ESC_BYTE, 8'h00, ESC_BYTE, 8'hFF, 8'h00,
			64'h1A00FF1A1A5AA51A);
		run_random(62);

		drain_results();
		tx_gap_pct = 50;
		rx_stall_pct = 34;
		load_settings(ESC_BYTE, 8'h00, 8'hFF, ESC_BYTE, 8'hFF, ESC_BYTE, ESC_BYTE,
			64'hFFFFFFFFFFFFFFFF);
		run_random(62);

		drain_results();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		load_settings(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			rand_byte(), rand_byte(),
			{rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			 rand_byte(), rand_byte(), rand_byte(), rand_byte()});
		run_random(62);

		drain_results();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
